// File: src/best_fit_chunk_allocator_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the best-fit chunk allocator
// ---------------------------------------------------------------------------
`ifndef BEST_FIT_CHUNK_ALLOCATOR_TOP_DEFINES_SVH
`define BEST_FIT_CHUNK_ALLOCATOR_TOP_DEFINES_SVH

// property checked on every clock, off during reset
`define BFCA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// condition that must never hold
`define BFCA_NEVER(label, expr, msg) \
  `BFCA_ASSERT(label, !(expr), msg)

`endif

// File: src/bfca_pkg.sv
// ---------------------------------------------------------------------------
// bfca_pkg
// Status codes, command codes and size classes of the chunk allocator.
// ---------------------------------------------------------------------------
package bfca_pkg;

  localparam logic [2:0] ST_REUSED     = 3'd0;
  localparam logic [2:0] ST_NEW        = 3'd1;
  localparam logic [2:0] ST_RELEASED   = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE  = 3'd3;
  localparam logic [2:0] ST_HEAP_OUT   = 3'd4;
  localparam logic [2:0] ST_NONE_ALLOC = 3'd5;
  localparam logic [2:0] ST_TABLE_FULL = 3'd6;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam int SIZE_W = 10;

  localparam logic [SIZE_W-1:0] CLASS_32  = 10'd32;
  localparam logic [SIZE_W-1:0] CLASS_64  = 10'd64;
  localparam logic [SIZE_W-1:0] CLASS_128 = 10'd128;
  localparam logic [SIZE_W-1:0] CLASS_256 = 10'd256;
  localparam logic [SIZE_W-1:0] CLASS_512 = 10'd512;
  localparam logic [SIZE_W-1:0] MAX_REQ   = CLASS_512;

  localparam int HEAP_W = 21;
  localparam logic [HEAP_W-1:0] HEAP_LIMIT_RST = 21'd1048576;

  localparam int OUT_ADDR_W = 20;

  typedef struct packed {
    logic [2:0]            status;
    logic [OUT_ADDR_W-1:0] addr;
    logic [SIZE_W-1:0]     size;
    logic [SIZE_W-1:0]     used;
  } result_t;

  function automatic logic [SIZE_W-1:0] class_of(input logic [SIZE_W-1:0] sz);
    logic [SIZE_W-1:0] c;
    if (sz <= CLASS_32) c = CLASS_32;
    else if (sz <= CLASS_64) c = CLASS_64;
    else if (sz <= CLASS_128) c = CLASS_128;
    else if (sz <= CLASS_256) c = CLASS_256;
    else c = CLASS_512;
    return c;
  endfunction

endpackage

// File: src/bfca_ram.sv
// ---------------------------------------------------------------------------
// bfca_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module bfca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/best_fit_chunk_allocator_top.sv
// Path per command: rejects go DISPATCH, EMIT; releases DISPATCH, REL_TBL, REL_OUT, EMIT;
//   allocations DISPATCH, SCAN, then SHIFT on reuse or BUMP_ALLOC for a new chunk, then EMIT.
// One command at a time: the next is accepted in IDLE, which EMIT enters as it raises
//   m_tvalid; a held result stalls the next one in EMIT.
// Reset (rst, synchronous): counters, pointers and heap_limit cleared to reset
//   values at once; RAM contents are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
// best_fit_chunk_allocator_top
// Best-fit allocator command engine: free list, allocated stack and chunk
// table held in RAMs, walked by a sequencer.
// ---------------------------------------------------------------------------
`include "best_fit_chunk_allocator_top_defines.svh"

module best_fit_chunk_allocator_top #(
  parameter int MAX_CHUNKS = 64,
  parameter int ADDR_BITS  = 20
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [15:0]  s_tdata,   // cmd, req_size
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,   // status, chunk_addr, chunk_size, used_size,
                                  // alloc_count, release_count
  input  logic         cfg_wen,
  input  logic [20:0]  cfg_wdata  // heap_limit
);

  import bfca_pkg::*;

  localparam int IW  = $clog2(MAX_CHUNKS);
  localparam int CW  = $clog2(MAX_CHUNKS + 1);
  localparam int LW  = ((ADDR_BITS > HEAP_W) ? ADDR_BITS : HEAP_W) + 2;
  localparam int BW  = ADDR_BITS + 1;
  localparam int TW  = ADDR_BITS + SIZE_W;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_CHUNKS);
  localparam logic [LW-1:0] SPAN  = LW'(1) << ADDR_BITS;

  typedef enum logic [3:0] {
    IDLE, DISPATCH, REL_TBL, REL_OUT, SCAN, SHIFT, BUMP_ALLOC, EMIT
  } state_t;

  state_t state;

  logic              cmd;
  logic [SIZE_W-1:0] req;
  logic [HEAP_W-1:0] heap_limit;

  logic [CW-1:0] chunks_created, alloc_depth, free_count;
  logic [BW-1:0] bump;
  logic [31:0]   new_cnt, rel_cnt;

  // scan pipeline
  logic [CW-1:0]     scan_i, p1_pos, p2_pos;
  logic              p1_v, p2_v;
  logic [IW-1:0]     p2_c;
  logic              found;
  logic [CW-1:0]     best_pos;
  logic [IW-1:0]     best_c;
  logic [SIZE_W-1:0] best_size;
  logic [ADDR_BITS-1:0] best_addr;

  // compaction
  logic [CW-1:0] sh_i, sh_wpos;
  logic          sh_v;

  result_t res;

  logic [2:0]            out_status;
  logic [OUT_ADDR_W-1:0] out_addr;
  logic [SIZE_W-1:0]     out_size, out_used;
  logic [31:0]           out_alloc, out_rel;

  // RAM ports
  logic          fl_we, stk_we, tbl_we;
  logic [IW-1:0] fl_waddr, fl_wdata, fl_raddr, fl_rdata;
  logic [IW-1:0] stk_waddr, stk_wdata, stk_raddr, stk_rdata;
  logic [IW-1:0] tbl_waddr, tbl_raddr;
  logic [TW-1:0] tbl_wdata, tbl_rdata;

  logic [SIZE_W-1:0]    tbl_size;
  logic [ADDR_BITS-1:0] tbl_addr;
  logic [SIZE_W-1:0]    cls;
  logic [LW-1:0]        lim, need, lim_ext;
  logic                 sh_more, sh_done, scan_done, new_ok, table_full, heap_out;

  assign tbl_size = tbl_rdata[SIZE_W-1:0];
  assign tbl_addr = tbl_rdata[TW-1:SIZE_W];
  assign cls      = class_of(req);
  assign lim_ext  = LW'(heap_limit);
  assign lim      = (lim_ext > SPAN) ? SPAN : lim_ext;
  assign need     = LW'(bump) + LW'(cls);

  assign table_full = (chunks_created >= MAX_C);
  assign heap_out   = (need > lim);
  assign new_ok     = !table_full && !heap_out;
  assign sh_more    = ((CW + 1)'(sh_i) + (CW + 1)'(1)) < (CW + 1)'(free_count);
  assign sh_done    = !sh_more && !sh_v;
  assign scan_done  = (scan_i == free_count) && !p1_v && !p2_v;

  assign s_tready = (state == IDLE);

  assign m_tdata = {5'd0, out_rel, out_alloc, out_used, out_size, out_addr, out_status};

  always_comb begin
    fl_we     = 1'b0;
    fl_waddr  = '0;
    fl_wdata  = '0;
    fl_raddr  = '0;
    stk_we    = 1'b0;
    stk_waddr = IW'(alloc_depth);
    stk_wdata = '0;
    stk_raddr = '0;
    tbl_we    = 1'b0;
    tbl_waddr = IW'(chunks_created);
    tbl_wdata = {bump[ADDR_BITS-1:0], cls};
    tbl_raddr = '0;
    case (state)
      DISPATCH: begin
        stk_raddr = IW'(alloc_depth - CW'(1));
      end
      REL_TBL: begin
        tbl_raddr = stk_rdata;
        if (free_count < MAX_C) begin
          fl_we    = 1'b1;
          fl_waddr = IW'(free_count);
          fl_wdata = stk_rdata;
        end
      end
      SCAN: begin
        fl_raddr  = IW'(scan_i);
        tbl_raddr = fl_rdata;
      end
      SHIFT: begin
        fl_raddr  = IW'(sh_i + CW'(1));
        fl_we     = sh_v;
        fl_waddr  = IW'(sh_wpos);
        fl_wdata  = fl_rdata;
        stk_we    = sh_done && (alloc_depth < MAX_C);
        stk_wdata = best_c;
      end
      BUMP_ALLOC: begin
        tbl_we    = new_ok;
        stk_we    = new_ok && (alloc_depth < MAX_C);
        stk_wdata = IW'(chunks_created);
      end
      default: begin
      end
    endcase
  end

  bfca_ram #(.WIDTH(IW), .DEPTH(MAX_CHUNKS)) u_free_list (
    .clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
    .raddr(fl_raddr), .rdata(fl_rdata)
  );

  bfca_ram #(.WIDTH(IW), .DEPTH(MAX_CHUNKS)) u_alloc_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  bfca_ram #(.WIDTH(TW), .DEPTH(MAX_CHUNKS)) u_chunk_table (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .raddr(tbl_raddr), .rdata(tbl_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      heap_limit     <= HEAP_LIMIT_RST;
      chunks_created <= '0;
      alloc_depth    <= '0;
      free_count     <= '0;
      bump           <= '0;
      new_cnt        <= '0;
      rel_cnt        <= '0;
      m_tvalid       <= 1'b0;
      p1_v           <= 1'b0;
      p2_v           <= 1'b0;
      sh_v           <= 1'b0;
      found          <= 1'b0;
    end else begin
      if (cfg_wen) begin
        heap_limit <= cfg_wdata;
      end
      if (m_tvalid && m_tready && (state != EMIT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            cmd   <= s_tdata[0];
            req   <= s_tdata[10:1];
            state <= DISPATCH;
          end
        end
        DISPATCH: begin
          if (cmd == CMD_RELEASE) begin
            if (alloc_depth == '0) begin
              res   <= '{ST_NONE_ALLOC, '0, '0, '0};
              state <= EMIT;
            end else begin
              state <= REL_TBL;
            end
          end else if (req > MAX_REQ) begin
            res   <= '{ST_TOO_LARGE, '0, '0, '0};
            state <= EMIT;
          end else begin
            scan_i <= '0;
            p1_v   <= 1'b0;
            p2_v   <= 1'b0;
            found  <= 1'b0;
            state  <= SCAN;
          end
        end
        REL_TBL: begin
          alloc_depth <= alloc_depth - CW'(1);
          if (free_count < MAX_C) begin
            free_count <= free_count + CW'(1);
          end
          rel_cnt <= rel_cnt + 32'd1;
          state   <= REL_OUT;
        end
        REL_OUT: begin
          res   <= '{ST_RELEASED, OUT_ADDR_W'(tbl_addr), tbl_size, '0};
          state <= EMIT;
        end
        SCAN: begin
          if (scan_done) begin
            if (found) begin
              sh_i  <= best_pos;
              sh_v  <= 1'b0;
              state <= SHIFT;
            end else begin
              state <= BUMP_ALLOC;
            end
          end else begin
            if (scan_i < free_count) begin
              p1_v   <= 1'b1;
              p1_pos <= scan_i;
              scan_i <= scan_i + CW'(1);
            end else begin
              p1_v <= 1'b0;
            end
            p2_v   <= p1_v;
            p2_pos <= p1_pos;
            p2_c   <= fl_rdata;
            // strict less-than keeps the earliest of equal sizes
            if (p2_v && (tbl_size >= req) && (!found || (tbl_size < best_size))) begin
              found     <= 1'b1;
              best_size <= tbl_size;
              best_pos  <= p2_pos;
              best_c    <= p2_c;
              best_addr <= tbl_addr;
            end
          end
        end
        SHIFT: begin
          if (sh_done) begin
            free_count <= free_count - CW'(1);
            if (alloc_depth < MAX_C) begin
              alloc_depth <= alloc_depth + CW'(1);
            end
            res   <= '{ST_REUSED, OUT_ADDR_W'(best_addr), best_size, req};
            state <= EMIT;
          end else begin
            sh_v    <= sh_more;
            sh_wpos <= sh_i;
            if (sh_more) begin
              sh_i <= sh_i + CW'(1);
            end
          end
        end
        BUMP_ALLOC: begin
          if (table_full) begin
            res <= '{ST_TABLE_FULL, '0, '0, '0};
          end else if (heap_out) begin
            res <= '{ST_HEAP_OUT, '0, '0, '0};
          end else begin
            chunks_created <= chunks_created + CW'(1);
            bump           <= BW'(need);
            new_cnt        <= new_cnt + 32'd1;
            if (alloc_depth < MAX_C) begin
              alloc_depth <= alloc_depth + CW'(1);
            end
            res <= '{ST_NEW, OUT_ADDR_W'(bump[ADDR_BITS-1:0]), cls, req};
          end
          state <= EMIT;
        end
        EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            out_status <= res.status;
            out_addr   <= res.addr;
            out_size   <= res.size;
            out_used   <= res.used;
            out_alloc  <= new_cnt;
            out_rel    <= rel_cnt;
            state      <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // every created chunk is either free or allocated
  `BFCA_ASSERT(a_chunk_balance,
    ((CW + 1)'(free_count) + (CW + 1)'(alloc_depth)) == (CW + 1)'(chunks_created),
    "free plus allocated chunks differ from created chunks")

  `BFCA_NEVER(a_bump_in_span, (LW'(bump) > SPAN), "bump pointer beyond heap span")

  `BFCA_ASSERT(a_accept_dispatch, (s_tvalid && s_tready) |=> (state == DISPATCH),
    "accepted transaction not dispatched")

  `BFCA_ASSERT(a_result_from_emit, $rose(m_tvalid) |-> ($past(state) == EMIT),
    "result raised outside emit")

endmodule
